>>> hdl/rbr_pkg.sv
// rbr_pkg: shared types and fixed widths of the rolling-ball rotation block
// used by rbr_mat and rolling_ball_rotation; depends on nothing
package rbr_pkg;

    localparam int DELTA_W = 13;
    localparam int RAD_W   = 12;
    localparam int SQ_W    = 2 * DELTA_W;
    localparam int RAD2_W  = 2 * RAD_W;
    localparam int OUT_W   = 18;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 168;
    localparam logic [RAD_W-1:0] RAD_RESET = 12'd100;

    // sign and zero-movement flags that travel with an item
    typedef struct packed {
        logic sx;
        logic sy;
        logic drz;
    } t_flags;

    // one result, first member in the top bits so right_x lands lowest
    typedef struct packed {
        logic signed [OUT_W-1:0] forward_z;
        logic signed [OUT_W-1:0] forward_y;
        logic signed [OUT_W-1:0] forward_x;
        logic signed [OUT_W-1:0] up_z;
        logic signed [OUT_W-1:0] up_y;
        logic signed [OUT_W-1:0] up_x;
        logic signed [OUT_W-1:0] right_z;
        logic signed [OUT_W-1:0] right_y;
        logic signed [OUT_W-1:0] right_x;
    } t_matrix;

endpackage

>>> hdl/rbr_isqrt.sv
// rbr_isqrt: pipelined integer square root, one root bit per register stage
// generic; no package needed
module rbr_isqrt #(
    parameter int IN_W   = 58,
    parameter int SIDE_W = 8,
    localparam int RT_W  = (IN_W + 1) / 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IN_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [RT_W-1:0]   o_root,
    output logic [IN_W-1:0]   o_rem,
    output logic [SIDE_W-1:0] o_side
);

    localparam int DW = 2 * RT_W + 1;

    logic              r_val  [RT_W];
    logic [IN_W-1:0]   r_rem  [RT_W];
    logic [RT_W-1:0]   r_root [RT_W];
    logic [SIDE_W-1:0] r_side [RT_W];

    genvar k;
    for (k = 0; k < RT_W; k++) begin : g_stage
        localparam int B = RT_W - 1 - k;
        logic              w_val;
        logic [IN_W-1:0]   w_rem;
        logic [RT_W-1:0]   w_root;
        logic [SIDE_W-1:0] w_side;
        logic [DW-1:0]     w_delta;
        logic [DW-1:0]     w_rem_ext;
        logic              w_take;
        logic [IN_W-1:0]   n_rem;
        logic [RT_W-1:0]   n_root;

        // stage input: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign w_val  = i_valid;
            assign w_rem  = i_rad;
            assign w_root = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_val  = r_val[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_side = r_side[k-1];
        end

        // try this bit: (r + 2^b)^2 - r^2 against the remainder
        assign w_delta   = (DW'(w_root) << (B + 1)) | (DW'(1) << (2 * B));
        assign w_rem_ext = DW'(w_rem);
        assign w_take    = (w_rem_ext >= w_delta);
        assign n_rem     = w_take ? IN_W'(w_rem_ext - w_delta) : w_rem;
        assign n_root    = w_take ? (w_root | (RT_W'(1) << B)) : w_root;

        // valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k] <= 1'b0;
            end else if (i_en) begin
                r_val[k] <= w_val;
            end
        end

        // payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_val[RT_W-1];
    assign o_root  = r_root[RT_W-1];
    assign o_rem   = r_rem[RT_W-1];
    assign o_side  = r_side[RT_W-1];

endmodule

>>> hdl/rbr_div.sv
// rbr_div: pipelined restoring divider, several lanes, one quotient bit per stage
// generic; no package needed
module rbr_div #(
    parameter int LANES  = 4,
    parameter int NUM_W  = 45,
    parameter int DEN_W  = 30,
    parameter int Q_W    = 17,
    parameter int SIDE_W = 3,
    localparam int CW    = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][NUM_W-1:0] i_num,
    input  logic [LANES-1:0][DEN_W-1:0] i_den,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [LANES-1:0][Q_W-1:0]   o_quo,
    output logic [SIDE_W-1:0]           o_side
);

    logic                        r_val  [Q_W];
    logic [LANES-1:0][CW-1:0]    r_rem  [Q_W];
    logic [LANES-1:0][DEN_W-1:0] r_den  [Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_quo  [Q_W];
    logic [SIDE_W-1:0]           r_side [Q_W];

    genvar k;
    for (k = 0; k < Q_W; k++) begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic                        w_val;
        logic [LANES-1:0][CW-1:0]    w_rem;
        logic [LANES-1:0][DEN_W-1:0] w_den;
        logic [LANES-1:0][Q_W-1:0]   w_quo;
        logic [SIDE_W-1:0]           w_side;
        logic [LANES-1:0][CW-1:0]    n_rem;
        logic [LANES-1:0][Q_W-1:0]   n_quo;

        // stage input
        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    w_rem[l] = CW'(i_num[l]);
                end
            end
            assign w_val  = i_valid;
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_val  = r_val[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_den  = r_den[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_side = r_side[k-1];
        end

        // compare and subtract the shifted divisor in every lane
        always_comb begin
            logic [CW-1:0] sub;
            for (int l = 0; l < LANES; l++) begin
                sub = CW'(w_den[l]) << B;
                if (w_rem[l] >= sub) begin
                    n_rem[l] = w_rem[l] - sub;
                    n_quo[l] = w_quo[l] | (Q_W'(1) << B);
                end else begin
                    n_rem[l] = w_rem[l];
                    n_quo[l] = w_quo[l];
                end
            end
        end

        // valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k] <= 1'b0;
            end else if (i_en) begin
                r_val[k] <= w_val;
            end
        end

        // payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= w_den;
                r_quo[k]  <= n_quo;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_val[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

>>> hdl/rbr_mat.sv
// rbr_mat: signs, fixed-point products and matrix assembly in four stages
// depends on rbr_pkg
module rbr_mat #(
    parameter int FRAC_BITS = 16,
    localparam int Q_W      = FRAC_BITS + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [3:0][Q_W-1:0]   i_quo,     // cos, sin, ax, ay magnitudes
    input  rbr_pkg::t_flags       i_flags,
    output logic                  o_valid,
    output rbr_pkg::t_matrix      o_mat
);

    import rbr_pkg::*;

    localparam int SW = FRAC_BITS + 2;
    localparam int PW = 2 * SW;

    logic r_va, r_vb, r_vc, r_vd;

    logic signed [SW-1:0] r_cs_a, r_sn_a, r_c1_a, r_ax_a, r_ay_a;
    logic signed [SW-1:0] r_cs_b, r_c1_b, r_xx_b, r_yy_b, r_xy_b, r_fx_b, r_fy_b;
    logic signed [SW-1:0] r_cs_c, r_fx_c, r_fy_c, r_mxx_c, r_myy_c, r_mxy_c;
    t_matrix              r_mat;

    logic signed [SW-1:0] n_ax, n_ay;
    logic signed [PW-1:0] n_xx, n_yy, n_xy, n_fx, n_fy;
    logic signed [PW-1:0] n_mxx, n_myy, n_mxy;
    logic signed [SW:0]   n_rx, n_uy, n_ux, n_rz, n_uz;

    // stage a: signed ratios, zero when there is no movement
    always_comb begin
        n_ax = $signed({1'b0, i_quo[2]});
        n_ay = $signed({1'b0, i_quo[3]});
        if (i_flags.sx) begin
            n_ax = -n_ax;
        end
        if (i_flags.sy) begin
            n_ay = -n_ay;
        end
        if (i_flags.drz) begin
            n_ax = '0;
            n_ay = '0;
        end
    end

    // stage b: first products
    assign n_xx = r_ax_a * r_ax_a;
    assign n_yy = r_ay_a * r_ay_a;
    assign n_xy = r_ax_a * r_ay_a;
    assign n_fx = r_ax_a * r_sn_a;
    assign n_fy = r_ay_a * r_sn_a;

    // stage c: times one minus cosine
    assign n_mxx = r_xx_b * r_c1_b;
    assign n_myy = r_yy_b * r_c1_b;
    assign n_mxy = r_xy_b * r_c1_b;

    // stage d: sums and negations
    assign n_rx = (SW+1)'(r_cs_c) + (SW+1)'(r_myy_c);
    assign n_uy = (SW+1)'(r_cs_c) + (SW+1)'(r_mxx_c);
    assign n_ux = -(SW+1)'(r_mxy_c);
    assign n_rz = -(SW+1)'(r_fx_c);
    assign n_uz = -(SW+1)'(r_fy_c);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cs_a  <= $signed({1'b0, i_quo[0]});
            r_sn_a  <= $signed({1'b0, i_quo[1]});
            r_c1_a  <= (SW'(1) <<< FRAC_BITS) - $signed({1'b0, i_quo[0]});
            r_ax_a  <= n_ax;
            r_ay_a  <= n_ay;

            r_cs_b  <= r_cs_a;
            r_c1_b  <= r_c1_a;
            r_xx_b  <= SW'(n_xx >>> FRAC_BITS);
            r_yy_b  <= SW'(n_yy >>> FRAC_BITS);
            r_xy_b  <= SW'(n_xy >>> FRAC_BITS);
            r_fx_b  <= SW'(n_fx >>> FRAC_BITS);
            r_fy_b  <= SW'(n_fy >>> FRAC_BITS);

            r_cs_c  <= r_cs_b;
            r_fx_c  <= r_fx_b;
            r_fy_c  <= r_fy_b;
            r_mxx_c <= SW'(n_mxx >>> FRAC_BITS);
            r_myy_c <= SW'(n_myy >>> FRAC_BITS);
            r_mxy_c <= SW'(n_mxy >>> FRAC_BITS);

            r_mat.right_x   <= OUT_W'(n_rx);
            r_mat.right_y   <= OUT_W'(n_ux);
            r_mat.right_z   <= OUT_W'(n_rz);
            r_mat.up_x      <= OUT_W'(n_ux);
            r_mat.up_y      <= OUT_W'(n_uy);
            r_mat.up_z      <= OUT_W'(n_uz);
            r_mat.forward_x <= OUT_W'(r_fx_c);
            r_mat.forward_y <= OUT_W'(r_fy_c);
            r_mat.forward_z <= OUT_W'(r_cs_c);
        end
    end

    assign o_valid = r_vd;
    assign o_mat   = r_mat;

endmodule

>>> hdl/rolling_ball_rotation.sv
// rolling_ball_rotation: top level, entry stage, root glue and pipeline wiring
// depends on rbr_pkg, rbr_isqrt, rbr_div, rbr_mat
//
// Usage: each request on s_axis carries one mouse delta (dx, dy); m_axis returns
// the nine entries of the rolling-ball rotation matrix in signed fixed point
// with FRAC_BITS fraction bits, masked to 18 bits each.
// The cfg channel writes the 12-bit ball radius (reset value 100, zero acts
// as 1); o_cfg_ready is always high.
// The pipeline is one entry stage, one stage per bit of the first root, one
// glue stage, one stage per bit of the second root, one stage per quotient bit
// of the four parallel dividers and four product stages. One request is taken
// every cycle while the common enable is high.
// The whole pipeline moves on a common enable: while m_axis_tready is low
// and a result is waiting, everything holds and s_axis_tready is low; bubbles
// are filled while the output is empty. Synchronous reset clears all valid
// bits; payload registers are not reset.
module rolling_ball_rotation #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rbr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // mouse_dx, mouse_dy
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // right_x, right_y, right_z, up_x, up_y, up_z, forward_x, forward_y, forward_z
    output logic [rbr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rbr_pkg::RAD_W-1:0]        i_cfg_data     // ball_radius
);

    import rbr_pkg::*;

    localparam int IN1_W = SQ_W + 2 * FRAC_BITS;
    localparam int RT1_W = (IN1_W + 1) / 2;
    localparam int IN2_W = SQ_W + 1 + 2 * FRAC_BITS;
    localparam int RT2_W = (IN2_W + 1) / 2;
    localparam int NUM_W = DELTA_W + 2 * FRAC_BITS;
    localparam int Q_W   = FRAC_BITS + 1;

    typedef struct packed {
        logic [RAD_W-1:0]   rad;
        logic [RAD2_W-1:0]  rad2;
        logic [SQ_W-1:0]    n;
        logic [DELTA_W-1:0] mx;
        logic [DELTA_W-1:0] my;
        t_flags             flags;
    } t_side1;

    typedef struct packed {
        logic [RAD_W-1:0]   rad;
        logic [RT1_W-1:0]   dr;
        logic [DELTA_W-1:0] mx;
        logic [DELTA_W-1:0] my;
        t_flags             flags;
    } t_side2;

    logic en;

    // configuration register
    logic [RAD_W-1:0] r_radius;

    // entry stage
    logic                        r_v0;
    t_side1                      r_s0;
    logic signed [DELTA_W-1:0]   w_dx, w_dy;
    logic [DELTA_W-1:0]          w_mx, w_my;
    logic [RAD_W-1:0]            w_rad;
    t_side1                      n_s0;

    // first root
    logic               v1;
    logic [RT1_W-1:0]   dr;
    logic [IN1_W-1:0]   rem1;
    t_side1             s1;

    // glue stage
    logic               r_vg;
    logic [IN2_W-1:0]   r_g_in;
    t_side2             r_sg;

    // second root
    logic               v2;
    logic [RT2_W-1:0]   denom;
    t_side2             s2;

    // dividers
    logic                        v3;
    logic [3:0][NUM_W-1:0]       w_num;
    logic [3:0][RT2_W-1:0]       w_den;
    logic [3:0][Q_W-1:0]         quo;
    t_flags                      f3;

    t_matrix mat;

    // one enable for the whole pipeline
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_RESET;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_data;
        end
    end

    // unpack, magnitudes, squares and flags
    assign w_dx  = $signed(s_axis_tdata[DELTA_W-1:0]);
    assign w_dy  = $signed(s_axis_tdata[2*DELTA_W-1:DELTA_W]);
    assign w_mx  = w_dx[DELTA_W-1] ? DELTA_W'(-w_dx) : DELTA_W'(w_dx);
    assign w_my  = w_dy[DELTA_W-1] ? DELTA_W'(-w_dy) : DELTA_W'(w_dy);
    assign w_rad = (r_radius == '0) ? RAD_W'(1) : r_radius;

    always_comb begin
        n_s0.rad       = w_rad;
        n_s0.rad2      = RAD2_W'(w_rad) * RAD2_W'(w_rad);
        n_s0.n         = SQ_W'(w_mx) * SQ_W'(w_mx) + SQ_W'(w_my) * SQ_W'(w_my);
        n_s0.mx        = w_mx;
        n_s0.my        = w_my;
        n_s0.flags.sx  = w_dx[DELTA_W-1];
        n_s0.flags.sy  = !w_dy[DELTA_W-1] && (w_dy != '0);
        n_s0.flags.drz = (w_dx == '0) && (w_dy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_vg <= 1'b0;
        end else if (en) begin
            r_v0 <= s_axis_tvalid;
            r_vg <= v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= n_s0;
            // radius squared plus dr squared, where dr^2 = n*2^2F - remainder
            r_g_in <= (IN2_W'(s1.rad2) << (2 * FRAC_BITS))
                    + (IN2_W'(s1.n) << (2 * FRAC_BITS))
                    - IN2_W'(rem1);
            r_sg.rad   <= s1.rad;
            r_sg.dr    <= dr;
            r_sg.mx    <= s1.mx;
            r_sg.my    <= s1.my;
            r_sg.flags <= s1.flags;
        end
    end

    // distance root
    rbr_isqrt #(
        .IN_W   (IN1_W),
        .SIDE_W ($bits(t_side1))
    ) u_root1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v0),
        .i_rad   (IN1_W'(r_s0.n) << (2 * FRAC_BITS)),
        .i_side  (r_s0),
        .o_valid (v1),
        .o_root  (dr),
        .o_rem   (rem1),
        .o_side  (s1)
    );

    // hypotenuse root
    rbr_isqrt #(
        .IN_W   (IN2_W),
        .SIDE_W ($bits(t_side2))
    ) u_root2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vg),
        .i_rad   (r_g_in),
        .i_side  (r_sg),
        .o_valid (v2),
        .o_root  (denom),
        .o_rem   (),
        .o_side  (s2)
    );

    // cosine, sine and the two direction ratios
    assign w_num[0] = NUM_W'(s2.rad) << (2 * FRAC_BITS);
    assign w_num[1] = NUM_W'(s2.dr) << FRAC_BITS;
    assign w_num[2] = NUM_W'(s2.mx) << (2 * FRAC_BITS);
    assign w_num[3] = NUM_W'(s2.my) << (2 * FRAC_BITS);
    assign w_den[0] = denom;
    assign w_den[1] = denom;
    assign w_den[2] = RT2_W'(s2.dr);
    assign w_den[3] = RT2_W'(s2.dr);

    rbr_div #(
        .LANES  (4),
        .NUM_W  (NUM_W),
        .DEN_W  (RT2_W),
        .Q_W    (Q_W),
        .SIDE_W ($bits(t_flags))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v2),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_side  (s2.flags),
        .o_valid (v3),
        .o_quo   (quo),
        .o_side  (f3)
    );

    // products and output register
    rbr_mat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v3),
        .i_quo   (quo),
        .i_flags (f3),
        .o_valid (m_axis_tvalid),
        .o_mat   (mat)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - $bits(t_matrix))'(0), mat};

endmodule
